// ===== rtl/gc3_pkg.sv =====
// Shared types and constants of the 3x3 Gaussian blur filter.
`default_nettype none

package gc3_pkg;

   localparam int PIXEL_WIDTH   = 8;
   localparam int ROW_WIDTH     = 12;
   localparam int OUT_COL_WIDTH = 10;
   localparam int CFG_WIDTH_W   = 11;
   localparam int CSR_DATA_W    = 12;
   localparam int CSR_INDEX_W   = 1;
   localparam int SUM_WIDTH     = 12;

   // Response queue sizing.
   localparam int RSP_DEPTH       = 8;
   localparam int RSP_PTR_WIDTH   = 3;
   localparam int RSP_COUNT_WIDTH = 4;

   // Request opcodes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [PIXEL_WIDTH-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0]   filtered;
      logic [ROW_WIDTH-1:0]     out_row;
      logic [OUT_COL_WIDTH-1:0] out_column;
      logic                     last;
      logic                     frame_done;
   } rsp_type;

   // Pushes into the response queue; the second is only used with the first.
   typedef struct packed {
      logic first;
      logic second;
   } rsp_push_type;

endpackage

`default_nettype wire

// ===== rtl/gc3_rsp_fifo.sv =====
// Response queue that takes up to two responses per cycle and gives out one.
`default_nettype none

module gc3_rsp_fifo
   import gc3_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rsp_push_type               push,
   input  wire rsp_type                    push_data0,
   input  wire rsp_type                    push_data1,
   output logic [RSP_COUNT_WIDTH-1:0]      count,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_type                         rsp_data
);

   rsp_type                      entry_ff [RSP_DEPTH];
   logic [RSP_PTR_WIDTH-1:0]     head_ff, head_in;
   logic [RSP_PTR_WIDTH-1:0]     tail_ff, tail_in;
   logic [RSP_COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                         pop;
   logic [RSP_PTR_WIDTH-1:0]     tail_next;

   assign pop       = rsp_valid && rsp_ready;
   assign tail_next = tail_ff + RSP_PTR_WIDTH'(1);

   always_comb begin
      head_in  = pop ? head_ff + RSP_PTR_WIDTH'(1) : head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push.first && push.second) begin
         tail_in = tail_ff + RSP_PTR_WIDTH'(2);
      end else if (push.first) begin
         tail_in = tail_next;
      end
      count_in = count_ff + RSP_COUNT_WIDTH'(push.first) + RSP_COUNT_WIDTH'(push.second)
                 - RSP_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[tail_ff] <= push_data0;
      end
      if (push.first && push.second) begin
         entry_ff[tail_next] <= push_data1;
      end
   end

   assign count     = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[head_ff];

endmodule

`default_nettype wire

// ===== rtl/gaussian_3x3_convolution.sv =====
// Top level of the 3x3 Gaussian blur filter: line store, window and control.
// The filter takes one request per clock while req_ready is high: a pixel in
// raster order or, once the frame is complete, a drain step that gives out one
// pixel of the last row. Both previous rows live in one MAX_WIDTH-entry memory
// with one read and one write port; a request reads its column on acceptance
// and the read data feeds the window and the adders in the next cycle. A pixel
// at the end of a row gives two responses and the first pixel of the next row
// gives none, so with the response side always ready the input takes a request
// every cycle. When responses back up, the input stalls while the eight-entry
// output queue holds more than four responses, or more than six with stage two
// empty. Pixels sent while draining and drain steps sent mid-frame give no
// response. The memory needs no clearing pass after reset; the user must write
// the image size registers through the csr port only while no request is in
// flight, and the block does not enforce this.
`default_nettype none

module gaussian_3x3_convolution
   import gc3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int COL_WIDTH = $clog2(MAX_WIDTH);

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] two_above;
      logic [PIXEL_WIDTH-1:0] above;
   } column_type;

   typedef struct packed {
      logic                   drain;
      logic [PIXEL_WIDTH-1:0] pixel;
      logic [ROW_WIDTH-1:0]   row;
      logic [COL_WIDTH-1:0]   col;
      logic                   row_ge1;
      logic                   row_ge2;
      logic                   col_ge1;
      logic                   col_ge2;
      logic                   col_end;
      logic                   prv_ok;
      logic                   cur_ok;
      logic                   nxt_ok;
   } stage_type;

   function automatic logic [SUM_WIDTH-1:0] tap_sum(input logic [PIXEL_WIDTH-1:0] a,
                                                    input logic [PIXEL_WIDTH-1:0] b,
                                                    input logic [PIXEL_WIDTH-1:0] c);
      tap_sum = SUM_WIDTH'(a) + (SUM_WIDTH'(b) << 1) + SUM_WIDTH'(c);
   endfunction

   // Configuration.
   logic [CFG_WIDTH_W-1:0] width_ff;
   logic [ROW_WIDTH-1:0]   height_ff;
   logic [COL_WIDTH-1:0]   wlast;
   logic [ROW_WIDTH-1:0]   hlast;

   // Control state.
   logic [COL_WIDTH-1:0]   col_ff, col_in;
   logic [ROW_WIDTH-1:0]   row_ff, row_in;
   logic [COL_WIDTH-1:0]   drain_col_ff, drain_col_in;
   logic                   draining_ff, draining_in;

   // Line store and read path.
   column_type             line_mem [MAX_WIDTH];
   column_type             rd_ff;
   logic [COL_WIDTH-1:0]   raddr;
   logic                   wr_en;
   logic [COL_WIDTH-1:0]   waddr;
   column_type             wdata;

   // Second stage.
   logic                   s2_valid_ff;
   stage_type              s2_ff, s2_in;
   logic [PIXEL_WIDTH-1:0] win_ff [3][3];
   logic [PIXEL_WIDTH-1:0] win_new [3][3];
   column_type             col0_ff;
   column_type             dprv_ff, dcur_ff;
   column_type             cur_v, prv_m, cur_m, nxt_m;
   logic [PIXEL_WIDTH-1:0] top, mid;

   logic                   req_fire, is_pixel, take;
   logic                   col_end, row_end, drain_end;
   logic [SUM_WIDTH-1:0]   sum_a, sum_b, sum_d;
   logic [RSP_COUNT_WIDTH-1:0] count;
   logic [RSP_COUNT_WIDTH:0]   need;
   rsp_push_type           push;
   rsp_type                res0, res1;

   // ---------------------------------------------------------------- config
   always_comb begin
      if (width_ff < CFG_WIDTH_W'(2)) begin
         wlast = COL_WIDTH'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wlast = COL_WIDTH'(MAX_WIDTH - 1);
      end else begin
         wlast = COL_WIDTH'(width_ff - CFG_WIDTH_W'(1));
      end
      hlast = (height_ff < ROW_WIDTH'(2)) ? ROW_WIDTH'(1) : height_ff - ROW_WIDTH'(1);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_WIDTH_W'(640);
         height_ff <= ROW_WIDTH'(480);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- stage one
   assign need      = (RSP_COUNT_WIDTH+1)'(count) + (s2_valid_ff ? (RSP_COUNT_WIDTH+1)'(2) : '0)
                      + (RSP_COUNT_WIDTH+1)'(2);
   assign req_ready = (need <= (RSP_COUNT_WIDTH+1)'(RSP_DEPTH));
   assign req_fire  = req_valid && req_ready;
   assign is_pixel  = (req_data.op == OP_PIXEL);
   // A pixel counts only outside the drain, a drain step only inside it.
   assign take      = req_fire && (is_pixel ? !draining_ff : draining_ff);
   assign col_end   = (col_ff >= wlast);
   assign row_end   = (row_ff >= hlast);
   assign drain_end = (drain_col_ff >= wlast);
   assign raddr     = is_pixel ? col_ff : drain_col_ff + COL_WIDTH'(1);

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      drain_col_in = drain_col_ff;
      draining_in  = draining_ff;
      if (take) begin
         if (is_pixel) begin
            if (col_end) begin
               col_in = '0;
               if (row_end) begin
                  draining_in  = 1'b1;
                  drain_col_in = '0;
               end else begin
                  row_in = row_ff + ROW_WIDTH'(1);
               end
            end else begin
               col_in = col_ff + COL_WIDTH'(1);
            end
         end else begin
            if (drain_end) begin
               draining_in  = 1'b0;
               drain_col_in = '0;
               row_in       = '0;
               col_in       = '0;
            end else begin
               drain_col_in = drain_col_ff + COL_WIDTH'(1);
            end
         end
      end
   end

   always_comb begin
      s2_in         = '0;
      s2_in.drain   = !is_pixel;
      s2_in.pixel   = req_data.pixel;
      s2_in.row     = row_ff;
      s2_in.row_ge1 = (row_ff >= ROW_WIDTH'(1));
      s2_in.row_ge2 = (row_ff >= ROW_WIDTH'(2));
      if (is_pixel) begin
         s2_in.col     = col_ff;
         s2_in.col_ge1 = (col_ff >= COL_WIDTH'(1));
         s2_in.col_ge2 = (col_ff >= COL_WIDTH'(2));
         s2_in.col_end = col_end;
      end else begin
         s2_in.col     = drain_col_ff;
         s2_in.col_ge1 = (drain_col_ff != '0);
         s2_in.col_end = drain_end;
         s2_in.prv_ok  = (drain_col_ff != '0) &&
                         ({1'b0, drain_col_ff} <= {1'b0, wlast} + (COL_WIDTH+1)'(1));
         s2_in.cur_ok  = (drain_col_ff <= wlast);
         s2_in.nxt_ok  = (drain_col_ff < wlast);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         drain_col_ff <= '0;
         draining_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_col_ff <= drain_col_in;
         draining_ff  <= draining_in;
         s2_valid_ff  <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s2_ff <= s2_in;
      end
   end

   // ------------------------------------------------------------ line store
   // A drain step can read the column the last pixel writes in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[waddr] <= wdata;
      end
      if (take) begin
         rd_ff <= (wr_en && (waddr == raddr)) ? wdata : line_mem[raddr];
      end
   end

   // ------------------------------------------------------------- stage two
   assign top   = s2_ff.row_ge2 ? rd_ff.two_above : '0;
   assign mid   = s2_ff.row_ge1 ? rd_ff.above : '0;
   assign wr_en = s2_valid_ff && !s2_ff.drain;
   assign waddr = s2_ff.col;
   assign wdata = '{two_above: mid, above: s2_ff.pixel};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_new[i][0] = win_ff[i][1];
         win_new[i][1] = win_ff[i][2];
      end
      win_new[0][2] = top;
      win_new[1][2] = mid;
      win_new[2][2] = s2_ff.pixel;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_ff <= win_new;
         if (s2_ff.col == '0) begin
            col0_ff <= wdata;
         end
      end
      if (s2_valid_ff && s2_ff.drain) begin
         dprv_ff <= cur_v;
         dcur_ff <= rd_ff;
      end
   end

   // Pixel sums: the window column index runs left to right.
   always_comb begin
      sum_a = (s2_ff.col_ge2 ? tap_sum(win_new[0][0], win_new[1][0], win_new[2][0]) : '0)
              + (tap_sum(win_new[0][1], win_new[1][1], win_new[2][1]) << 1)
              + tap_sum(win_new[0][2], win_new[1][2], win_new[2][2]);
      sum_b = tap_sum(win_new[0][1], win_new[1][1], win_new[2][1])
              + (tap_sum(win_new[0][2], win_new[1][2], win_new[2][2]) << 1);
   end

   // Drain sum over the last two rows; the first column comes from a copy of
   // the line store entry at column zero.
   always_comb begin
      cur_v = s2_ff.col_ge1 ? dcur_ff : col0_ff;
      prv_m = s2_ff.prv_ok ? dprv_ff : '0;
      cur_m = s2_ff.cur_ok ? cur_v : '0;
      nxt_m = s2_ff.nxt_ok ? rd_ff : '0;
      sum_d = tap_sum(prv_m.two_above, cur_m.two_above, nxt_m.two_above)
              + (tap_sum(prv_m.above, cur_m.above, nxt_m.above) << 1);
   end

   always_comb begin
      res0 = '0;
      res1 = '0;
      push = '0;
      if (s2_ff.drain) begin
         res0.filtered   = sum_d[SUM_WIDTH-1:4];
         res0.out_row    = s2_ff.row;
         res0.out_column = OUT_COL_WIDTH'(s2_ff.col);
         res0.last       = 1'b1;
         res0.frame_done = s2_ff.col_end;
         push.first      = s2_valid_ff;
      end else begin
         res0.filtered   = sum_a[SUM_WIDTH-1:4];
         res0.out_row    = s2_ff.row - ROW_WIDTH'(1);
         res0.out_column = OUT_COL_WIDTH'(s2_ff.col - COL_WIDTH'(1));
         res0.last       = !s2_ff.col_end;
         res1.filtered   = sum_b[SUM_WIDTH-1:4];
         res1.out_row    = s2_ff.row - ROW_WIDTH'(1);
         res1.out_column = OUT_COL_WIDTH'(s2_ff.col);
         res1.last       = 1'b1;
         push.first      = s2_valid_ff && s2_ff.row_ge1 && s2_ff.col_ge1;
         push.second     = s2_valid_ff && s2_ff.row_ge1 && s2_ff.col_ge1 && s2_ff.col_end;
      end
   end

   gc3_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (res0),
      .push_data1 (res1),
      .count      (count),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/gc3_checker.sv =====
// Port-level checks of the Gaussian blur filter and their binding.
`default_nettype none

module gc3_checker
   import gc3_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // The response queue is empty after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // The end of a frame is always the last response of its request.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.last)
      else $error("frame_done without last");

   // Both responses of a row end are queued together, so the second follows at once.
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid && rsp_data.last)
      else $error("first of a response pair not followed by its second");

endmodule

bind gaussian_3x3_convolution gc3_checker u_gc3_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the 3x3 Gaussian blur filter with random frames and stalls.
module testbench;
   import gc3_pkg::*;

   localparam int LINE_LEN = 1024;

   logic     clock;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_data = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_data;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   gaussian_3x3_convolution #(.MAX_WIDTH(LINE_LEN)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   req_type pixel_stream[$];
   rsp_type blur_expected[$];
   bit      no_gaps = 1'b0;
   int      hold_asks = 0;
   int      mismatches = 0;
   int      requests_taken = 0;
   int      pixels_checked = 0;
   int      frames_seen = 0;

   // Filter state as the testbench sees it.
   logic [10:0] width_reg;
   logic [11:0] height_reg;
   logic [7:0]  prev_row [LINE_LEN];
   logic [7:0]  prev2_row [LINE_LEN];
   logic [7:0]  nbhd [3][3];
   int unsigned pix_row, pix_col, flush_col;
   bit          flushing;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned active_width(int unsigned raw);
      if (raw < 2) return 2;
      if (raw > LINE_LEN) return LINE_LEN;
      return raw;
   endfunction

   function automatic int unsigned active_height(int unsigned raw);
      return (raw < 2) ? 2 : raw;
   endfunction

   function automatic int unsigned tap(int i, int j);
      return ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1);
   endfunction

   function automatic rsp_type blur_result(int unsigned sum, int unsigned row,
                                           int unsigned col, bit last, bit done);
      rsp_type e;
      e.filtered   = 8'(sum / 16);
      e.out_row    = 12'(row);
      e.out_column = 10'(col);
      e.last       = last;
      e.frame_done = done;
      return e;
   endfunction

   function automatic req_type request(logic op, logic [7:0] px);
      req_type rq;
      rq.op    = op;
      rq.pixel = px;
      return rq;
   endfunction

   task automatic predict_blur(req_type rq);
      int unsigned w, h, r, c, d, x, sum;
      logic [7:0]  top, mid;
      bit          row_end, done;
      w = active_width(width_reg);
      h = active_height(height_reg);
      if (rq.op == OP_PIXEL) begin
         if (flushing) return;
         r = pix_row;
         c = pix_col;
         mid = (r >= 1) ? prev_row[c] : 8'd0;
         top = (r >= 2) ? prev2_row[c] : 8'd0;
         for (int i = 0; i < 3; i++) begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
         end
         nbhd[0][2] = top;
         nbhd[1][2] = mid;
         nbhd[2][2] = rq.pixel;
         prev2_row[c] = mid;
         prev_row[c] = rq.pixel;
         row_end = (c >= w - 1);
         if (r >= 1 && c >= 1) begin
            sum = 0;
            for (int i = 0; i < 3; i++) begin
               if (c >= 2) sum += tap(i, 0) * nbhd[i][0];
               sum += tap(i, 1) * nbhd[i][1] + tap(i, 2) * nbhd[i][2];
            end
            blur_expected.push_back(blur_result(sum, r - 1, c - 1, !row_end, 1'b0));
            // The last column also finishes the pixel right of the window center.
            if (row_end) begin
               sum = 0;
               for (int i = 0; i < 3; i++)
                  sum += tap(i, 0) * nbhd[i][1] + tap(i, 1) * nbhd[i][2];
               blur_expected.push_back(blur_result(sum, r - 1, c, 1'b1, 1'b0));
            end
         end
         if (row_end) begin
            pix_col = 0;
            if (r >= h - 1) begin
               flushing = 1'b1;
               flush_col = 0;
            end else begin
               pix_row = r + 1;
            end
         end else begin
            pix_col = c + 1;
         end
      end else if (flushing) begin
         d = flush_col;
         sum = 0;
         for (int j = 0; j < 3; j++) begin
            if (d + j >= 1 && d + j - 1 < w) begin
               x = d + j - 1;
               sum += tap(0, j) * prev2_row[x] + tap(1, j) * prev_row[x];
            end
         end
         done = (d >= w - 1);
         blur_expected.push_back(blur_result(sum, pix_row, d, 1'b1, done));
         if (done) begin
            flushing = 1'b0;
            flush_col = 0;
            pix_row = 0;
            pix_col = 0;
         end else begin
            flush_col = d + 1;
         end
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_stream.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 29)) begin
            req_valid <= 1'b1;
            req_data <= pixel_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure, with one long hold on request.
   int hold_seen = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_gaps || ($urandom_range(0, 99) >= 29);
      end
   end

   // Prediction on accepted requests, then comparison of accepted responses.
   always @(posedge clock) begin
      rsp_type want, got;
      if (reset) begin
         width_reg = 11'd640;
         height_reg = 12'd480;
         pix_row = 0;
         pix_col = 0;
         flush_col = 0;
         flushing = 1'b0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               nbhd[i][j] = 8'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg = csr_data[10:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            requests_taken++;
            predict_blur(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (blur_expected.size() == 0) begin
               $error("unexpected response at row %0d column %0d",
                      got.out_row, got.out_column);
               mismatches++;
            end else begin
               want = blur_expected.pop_front();
               pixels_checked++;
               if (got.frame_done) frames_seen++;
               if (got.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, got %0d", want.filtered, got.filtered);
                  mismatches++;
               end
               if (got.out_row !== want.out_row) begin
                  $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                  mismatches++;
               end
               if (got.out_column !== want.out_column) begin
                  $error("out_column: expected %0d, got %0d", want.out_column, got.out_column);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  mismatches++;
               end
               if (got.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_stream.size() != 0 || req_valid || blur_expected.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_size(int unsigned w_raw, int unsigned h_raw);
      // Bit 11 has no meaning for the width, so it is toggled at random.
      write_reg(CSR_IMAGE_WIDTH, {1'($urandom), 11'(w_raw)});
      write_reg(CSR_IMAGE_HEIGHT, 12'(h_raw));
   endtask

   task automatic queue_frame(int unsigned w, int unsigned h, bit noisy);
      logic [7:0] px;
      for (int unsigned p = 0; p < w * h; p++) begin
         if (noisy && $urandom_range(0, 99) < 3)
            pixel_stream.push_back(request(OP_DRAIN, 8'($urandom)));
         case ($urandom_range(0, 9))
            0:       px = 8'h00;
            1:       px = 8'hFF;
            default: px = 8'($urandom);
         endcase
         pixel_stream.push_back(request(OP_PIXEL, px));
      end
      for (int unsigned d = 0; d < w; d++) begin
         if (noisy && $urandom_range(0, 99) < 3)
            pixel_stream.push_back(request(OP_PIXEL, 8'($urandom)));
         pixel_stream.push_back(request(OP_DRAIN, 8'($urandom)));
      end
      if (noisy && $urandom_range(0, 9) == 0)
         pixel_stream.push_back(request(OP_DRAIN, 8'($urandom)));
   endtask

   initial begin
      int unsigned w_raw, h_raw, w_eff, h_eff, random_items;
      random_items = 0;
      w_raw = 2;
      h_raw = 2;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Saturated 3x3 frame with stray requests at every stage.
      write_size(3, 3);
      pixel_stream.push_back(request(OP_DRAIN, 8'h5A));
      repeat (9) pixel_stream.push_back(request(OP_PIXEL, 8'hFF));
      pixel_stream.push_back(request(OP_PIXEL, 8'h00));
      repeat (3) pixel_stream.push_back(request(OP_DRAIN, 8'h00));
      pixel_stream.push_back(request(OP_DRAIN, 8'hFF));
      wait_idle();

      // Sizes below the minimum clamp to a 2x2 frame.
      write_size(1, 0);
      pixel_stream.push_back(request(OP_PIXEL, 8'h01));
      pixel_stream.push_back(request(OP_PIXEL, 8'h80));
      pixel_stream.push_back(request(OP_PIXEL, 8'h7F));
      pixel_stream.push_back(request(OP_PIXEL, 8'h00));
      repeat (2) pixel_stream.push_back(request(OP_DRAIN, 8'hA5));

      while (random_items < 450) begin
         if (random_items == 0 || $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0:       w_raw = $urandom_range(0, 1);
               default: w_raw = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 9))
               0:       h_raw = $urandom_range(0, 1);
               default: h_raw = $urandom_range(2, 10);
            endcase
            wait_idle();
            write_size(w_raw, h_raw);
         end
         w_eff = active_width(w_raw);
         h_eff = active_height(h_raw);
         queue_frame(w_eff, h_eff, 1'b1);
         random_items += w_eff * h_eff + w_eff;
      end

      // The output stalls for a long time once results flow, so the input backs up.
      wait_idle();
      write_size(24, 10);
      queue_frame(24, 10, 1'b1);
      while (blur_expected.size() == 0) @(negedge clock);
      hold_asks++;

      // Resize in the middle of a frame: the column and then the row are already past
      // the new end, so each counts as the end of its row or frame.
      wait_idle();
      write_size(20, 3);
      repeat (32) pixel_stream.push_back(request(OP_PIXEL, 8'($urandom)));
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 12'd8);
      repeat (5) pixel_stream.push_back(request(OP_PIXEL, 8'($urandom)));
      wait_idle();
      write_reg(CSR_IMAGE_HEIGHT, 12'd2);
      repeat (4) pixel_stream.push_back(request(OP_PIXEL, 8'($urandom)));
      repeat (8) pixel_stream.push_back(request(OP_DRAIN, 8'($urandom)));

      // A whole frame streamed with no gaps on either side.
      wait_idle();
      no_gaps = 1'b1;
      write_size(16, 10);
      queue_frame(16, 10, 1'b0);
      wait_idle();
      no_gaps = 1'b0;

      $display("Sent %0d requests over %0d frames; %0d filtered pixels compared.",
               requests_taken, frames_seen, pixels_checked);
      $display("Frames ran from 2x2 to 24x10 with stray requests, a long output stall,");
      $display("a mid-frame resize and one frame streamed without gaps.");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
